@@ design/tkps_pkg.sv @@
// ----------------------------------------------------------------------------
// tkps_pkg
// Shared types and constants of the top-K priority selector.
// ----------------------------------------------------------------------------
package tkps_pkg;

    localparam int MAX_K_DEF = 16;
    localparam int RANK_W    = 16;
    localparam int KEY_W     = 64;
    localparam int CFG_W     = 5;

    localparam logic [CFG_W-1:0] KEEP_COUNT_RESET = CFG_W'(1);

    typedef enum logic
    {
        MODE_OFFER = 1'b0,
        MODE_FLUSH = 1'b1
    } mode_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } state_t;

    typedef struct packed
    {
        logic [RANK_W-1:0] rank;
        logic [KEY_W-1:0]  key;
    } rec_t;

endpackage

@@ design/tkps_if.sv @@
// ----------------------------------------------------------------------------
// tkps_if
// Valid/ready channels of the top-K priority selector.
// ----------------------------------------------------------------------------
interface tkps_in_if;
    logic                          valid;
    logic                          ready;
    tkps_pkg::mode_t               mode;
    logic [tkps_pkg::RANK_W-1:0]   rank_value;
    logic [tkps_pkg::KEY_W-1:0]    record_key;

    modport source (output valid, output mode, output rank_value, output record_key,
                    input ready);
    modport sink   (input valid, input mode, input rank_value, input record_key,
                    output ready);
endinterface

interface tkps_out_if;
    logic                          valid;
    logic                          ready;
    logic [tkps_pkg::RANK_W-1:0]   out_rank;
    logic [tkps_pkg::KEY_W-1:0]    out_key;
    logic                          last_of_run;

    modport source (output valid, output out_rank, output out_key, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_rank, input out_key, input last_of_run,
                    output ready);
endinterface

interface tkps_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tkps_pkg::CFG_W-1:0]    keep_count;

    modport source (output valid, output keep_count, input ready);
    modport sink   (input valid, input keep_count, output ready);
endinterface

@@ design/tkps_cmp.sv @@
// ----------------------------------------------------------------------------
// tkps_cmp
// Shared record comparator: higher rank wins, equal ranks go to the smaller key.
// ----------------------------------------------------------------------------
module tkps_cmp
(
    input  tkps_pkg::rec_t a,
    input  tkps_pkg::rec_t b,
    output logic           above
);

    always_comb
    begin
        if (a.rank != b.rank)
        begin
            above = (a.rank > b.rank);
        end
        else
        begin
            above = (a.key < b.key);
        end
    end

endmodule

@@ design/tkps_store.sv @@
// ----------------------------------------------------------------------------
// tkps_store
// Record store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tkps_store #(
    parameter int MAX_K = tkps_pkg::MAX_K_DEF,
    localparam int AW   = (MAX_K > 1) ? $clog2(MAX_K) : 1
)
(
    input  logic           clk,
    input  logic           we,
    input  logic [AW-1:0]  waddr,
    input  tkps_pkg::rec_t wdata,
    input  logic [AW-1:0]  raddr,
    output tkps_pkg::rec_t rdata
);

    tkps_pkg::rec_t mem [MAX_K];
    tkps_pkg::rec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/tkps_ctrl.sv @@
// ----------------------------------------------------------------------------
// tkps_ctrl
// Sequencer that scans the store one entry per cycle through the comparator,
// replacing the worst record on an offer and selecting the best on a flush.
// ----------------------------------------------------------------------------
module tkps_ctrl #(
    parameter int MAX_K = tkps_pkg::MAX_K_DEF,
    localparam int AW   = (MAX_K > 1) ? $clog2(MAX_K) : 1
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [tkps_pkg::CFG_W-1:0] keep_count,
    tkps_in_if.sink                    records,
    tkps_out_if.source                 results,
    output logic                       st_we,
    output logic [AW-1:0]              st_waddr,
    output tkps_pkg::rec_t             st_wdata,
    output logic [AW-1:0]              st_raddr,
    input  tkps_pkg::rec_t             st_rdata
);

    localparam int CW = $clog2(MAX_K + 1);

    tkps_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic [CW-1:0]    emit_reg, emit_next;
    logic [AW-1:0]    cnt_reg, cnt_next;
    logic [AW-1:0]    pass_reg, pass_next;
    logic [AW-1:0]    best_idx_reg, best_idx_next;
    logic [AW-1:0]    ridx_reg, ridx_next;
    logic             rv_reg, rv_next;
    logic             flush_reg, flush_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_last_reg, out_last_next;
    tkps_pkg::rec_t   new_reg, new_next;
    tkps_pkg::rec_t   best_reg, best_next;
    tkps_pkg::rec_t   hold_reg, hold_next;
    tkps_pkg::rec_t   out_rec_reg, out_rec_next;

    tkps_pkg::rec_t   cmp_a;
    tkps_pkg::rec_t   cmp_b;
    tkps_pkg::rec_t   in_rec;
    logic             cmp_above;
    logic [CW-1:0]    lim;
    logic [CW-1:0]    emit_calc;
    logic [AW-1:0]    last_addr;
    logic             accept;
    logic             out_free;
    logic             final_pass;
    logic             first_entry;

    assign lim        = (int'(keep_count) > MAX_K) ? CW'(MAX_K) : CW'(keep_count);
    assign emit_calc  = (lim < fill_reg) ? lim : fill_reg;
    assign last_addr  = AW'(fill_reg - CW'(1));
    assign accept     = records.valid && records.ready;
    assign out_free   = !out_valid_reg || results.ready;
    assign final_pass = ((CW'(pass_reg) + CW'(1)) == emit_reg);
    assign first_entry = (ridx_reg == pass_reg);
    assign in_rec     = '{rank: records.rank_value, key: records.record_key};

    assign records.ready       = (state_reg == tkps_pkg::ST_IDLE);
    assign results.valid       = out_valid_reg;
    assign results.out_rank    = out_rec_reg.rank;
    assign results.out_key     = out_rec_reg.key;
    assign results.last_of_run = out_last_reg;

    always_comb
    begin
        if (state_reg == tkps_pkg::ST_DECIDE)
        begin
            cmp_a = new_reg;
            cmp_b = best_reg;
        end
        else if (flush_reg)
        begin
            cmp_a = st_rdata;
            cmp_b = best_reg;
        end
        else
        begin
            cmp_a = best_reg;
            cmp_b = st_rdata;
        end
    end

    tkps_cmp u_cmp
    (
        .a     (cmp_a),
        .b     (cmp_b),
        .above (cmp_above)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tkps_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (records.mode == tkps_pkg::MODE_FLUSH)
                    begin
                        if (emit_calc != '0)
                        begin
                            state_next = tkps_pkg::ST_SCAN;
                        end
                    end
                    else if ((lim != '0) && (fill_reg >= lim))
                    begin
                        state_next = tkps_pkg::ST_SCAN;
                    end
                end
            end
            tkps_pkg::ST_SCAN:
            begin
                if (cnt_reg == last_addr)
                begin
                    state_next = tkps_pkg::ST_DRAIN;
                end
            end
            tkps_pkg::ST_DRAIN:
            begin
                state_next = tkps_pkg::ST_DECIDE;
            end
            tkps_pkg::ST_DECIDE:
            begin
                if (!flush_reg)
                begin
                    state_next = tkps_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    state_next = final_pass ? tkps_pkg::ST_IDLE : tkps_pkg::ST_SCAN;
                end
            end
            default:
            begin
                state_next = tkps_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fill_next      = fill_reg;
        emit_next      = emit_reg;
        cnt_next       = cnt_reg;
        pass_next      = pass_reg;
        best_idx_next  = best_idx_reg;
        ridx_next      = ridx_reg;
        rv_next        = 1'b0;
        flush_next     = flush_reg;
        new_next       = new_reg;
        best_next      = best_reg;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        out_rec_next   = out_rec_reg;
        st_we          = 1'b0;
        st_waddr       = AW'(fill_reg);
        st_wdata       = in_rec;
        st_raddr       = cnt_reg;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        if ((state_reg == tkps_pkg::ST_SCAN || state_reg == tkps_pkg::ST_DRAIN) && rv_reg)
        begin
            if (first_entry || cmp_above)
            begin
                best_next     = st_rdata;
                best_idx_next = ridx_reg;
            end
            if (first_entry)
            begin
                hold_next = st_rdata;
            end
        end

        case (state_reg)
            tkps_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    flush_next = (records.mode == tkps_pkg::MODE_FLUSH);
                    new_next   = in_rec;
                    pass_next  = '0;
                    cnt_next   = '0;
                    if (records.mode == tkps_pkg::MODE_FLUSH)
                    begin
                        emit_next = emit_calc;
                        if (emit_calc == '0)
                        begin
                            fill_next = '0;
                        end
                    end
                    else if ((lim != '0) && (fill_reg < lim))
                    begin
                        st_we     = 1'b1;
                        fill_next = fill_reg + CW'(1);
                    end
                end
            end
            tkps_pkg::ST_SCAN:
            begin
                rv_next   = 1'b1;
                ridx_next = cnt_reg;
                if (cnt_reg != last_addr)
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            tkps_pkg::ST_DRAIN:
            begin
                rv_next = 1'b0;
            end
            tkps_pkg::ST_DECIDE:
            begin
                st_waddr = best_idx_reg;
                if (!flush_reg)
                begin
                    st_wdata = new_reg;
                    st_we    = cmp_above;
                end
                else if (out_free)
                begin
                    // The entry at the pass position moves into the slot of the
                    // selected record; the pass position is not read again.
                    st_wdata       = hold_reg;
                    st_we          = 1'b1;
                    out_valid_next = 1'b1;
                    out_rec_next   = best_reg;
                    out_last_next  = final_pass;
                    if (final_pass)
                    begin
                        fill_next = '0;
                    end
                    else
                    begin
                        pass_next = pass_reg + AW'(1);
                        cnt_next  = pass_reg + AW'(1);
                    end
                end
            end
            default:
            begin
                rv_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tkps_pkg::ST_IDLE;
            fill_reg      <= '0;
            rv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rv_reg        <= rv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        emit_reg     <= emit_next;
        cnt_reg      <= cnt_next;
        pass_reg     <= pass_next;
        best_idx_reg <= best_idx_next;
        ridx_reg     <= ridx_next;
        flush_reg    <= flush_next;
        new_reg      <= new_next;
        best_reg     <= best_next;
        hold_reg     <= hold_next;
        out_last_reg <= out_last_next;
        out_rec_reg  <= out_rec_next;
    end

    // The fill level never passes the store depth.
    assert property (@(posedge clk) disable iff (!rst_n) int'(fill_reg) <= MAX_K)
        else $error("fill level exceeds store depth");

    // Every write lands inside the store.
    assert property (@(posedge clk) disable iff (!rst_n) st_we |-> int'(st_waddr) < MAX_K)
        else $error("store write out of range");

    // Read data under comparison always belongs to a held record.
    assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg |-> CW'(ridx_reg) < fill_reg)
        else $error("scan read beyond fill level");

    // A flush either starts a scan or leaves the store empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && records.mode == tkps_pkg::MODE_FLUSH)
        |=> (state_reg == tkps_pkg::ST_SCAN || fill_reg == '0))
        else $error("flush neither scanned nor cleared the store");

endmodule

@@ design/top_k_priority_select.sv @@
// ----------------------------------------------------------------------------
// top_k_priority_select
// Keeps the best K records of a stream and emits them ranked on a flush.
// ----------------------------------------------------------------------------
// An offer into a store that is not yet full is written without a scan. An
// offer into a full store makes one comparator walk the store one entry per
// cycle through its single registered read port to find the worst record,
// then decide on the replacement. A flush that emits E of N held records runs
// one pass per emitted record; each pass scans the remaining entries for the
// best record and may wait while a result sits in the output register. The
// input is not ready while a scan runs, but the last result of a flush may
// wait in the output register while the next item is taken. No clearing pass
// is needed after reset.
module top_k_priority_select #(
    parameter int MAX_K = tkps_pkg::MAX_K_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    tkps_cfg_if.sink    config_wr,
    tkps_in_if.sink     records,
    tkps_out_if.source  results
);

    localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

    logic [tkps_pkg::CFG_W-1:0] keep_count_reg;
    logic [tkps_pkg::CFG_W-1:0] keep_count_next;
    logic                       st_we;
    logic [AW-1:0]              st_waddr;
    logic [AW-1:0]              st_raddr;
    tkps_pkg::rec_t             st_wdata;
    tkps_pkg::rec_t             st_rdata;

    assign config_wr.ready = 1'b1;
    assign keep_count_next = (config_wr.valid && config_wr.ready) ?
                             config_wr.keep_count : keep_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= tkps_pkg::KEEP_COUNT_RESET;
        end
        else
        begin
            keep_count_reg <= keep_count_next;
        end
    end

    tkps_store #(.MAX_K(MAX_K)) u_store
    (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    tkps_ctrl #(.MAX_K(MAX_K)) u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .keep_count (keep_count_reg),
        .records    (records),
        .results    (results),
        .st_we      (st_we),
        .st_waddr   (st_waddr),
        .st_wdata   (st_wdata),
        .st_raddr   (st_raddr),
        .st_rdata   (st_rdata)
    );

endmodule
